### src/tsa_pkg.sv
// Shared types and constants for the timed slot allocator.
// Used by tsa_ctrl, tsa_dpath and timed_slot_allocator_top; no dependencies.
package tsa_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int COUNT_W       = 16;
	localparam int SID_W         = 16;
	localparam int SLOT_W        = 4;
	localparam int MAX_EVENTS    = 16;
	localparam int EVCNT_W       = $clog2(MAX_EVENTS + 1);
	localparam int IN_DATA_W     = 32;
	localparam int OUT_DATA_W    = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// event kinds on the output tuser
	localparam logic EV_STOP  = 1'b0;
	localparam logic EV_START = 1'b1;

	// request kinds on the input tuser
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_PLAY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TFLUSH,
		ST_PSTOP,
		ST_PSTART
	} tsa_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;      // latch item, restart scan
		logic scan_adv;   // issue next slot read, retire evaluated slot
		logic scan_rep;   // stall: re-read the slot under evaluation
		logic wr_dec;     // write back decremented countdown
		logic min_upd;    // fold evaluated slot into the minimum search
		logic pick_ev;    // chosen slot = evaluated slot (free one found)
		logic pick_best;  // chosen slot = minimum slot (eviction)
		logic hold_ld;    // park stop item of evaluated slot
		logic hold_clr;
		logic out_hold;   // send parked stop item
		logic out_last;   // last flag with out_hold
		logic out_stop;   // send stop item for the minimum slot
		logic out_start;  // send start item for the chosen slot
		logic wr_dur;     // load duration into the chosen slot
	} tsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic play;
		logic ev_valid;
		logic ev_zero;
		logic ev_one;
		logic iss_done;
		logic hold_valid;
		logic out_free;
		logic cap_full;
	} tsa_sts_t;

endpackage

### src/timed_slot_allocator_top.sv
// Timed slot allocator: a countdown per slot, allocation on play, expiry on tick.
// An item is taken only while the block is idle. A tick scans the countdown memory
// one slot per cycle through its single read port, except where the scan re-reads a slot
// while a parked stop item waits for the output register; output stalls also keep the
// block busy. A play request ends its scan at the first free slot, or scans every slot
// and evicts the slot with the smallest countdown, and may also wait on output stalls.
// Results leave through an output register, so the next item is taken while
// the last result still waits.
// Depends on tsa_pkg, tsa_ctrl and tsa_dpath.
module timed_slot_allocator_top #(
	parameter int NUM_SLOTS = tsa_pkg::NUM_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [15:0] duration, [31:16] sound_id
	input  logic [tsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] slot_index, [19:4] sound_id_out, [23:20] zero
	output logic [tsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] event_kind
	output logic                           m_axis_tuser,
	output logic                           m_axis_tlast
);

	tsa_pkg::tsa_cmd_t cmd;
	tsa_pkg::tsa_sts_t sts;

	tsa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	tsa_dpath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_play       (s_axis_tuser == tsa_pkg::REQ_PLAY),
		.in_duration   (s_axis_tdata[15:0]),
		.in_sound_id   (s_axis_tdata[31:16]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### src/tsa_ctrl.sv
// Sequencer of the timed slot allocator: runs the tick and play scans.
// Depends on tsa_pkg; drives tsa_dpath through tsa_cmd_t.
module tsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  tsa_pkg::tsa_sts_t sts,
	output tsa_pkg::tsa_cmd_t cmd
);

	tsa_pkg::tsa_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		logic need_emit;
		need_emit     = sts.ev_valid && sts.ev_one && !sts.cap_full;
		cmd           = '0;
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			tsa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.start = 1'b1;
					state_nxt = tsa_pkg::ST_SCAN;
				end
			end
			tsa_pkg::ST_SCAN: begin
				if (sts.play) begin
					// first free slot ends the search
					if (sts.ev_valid && sts.ev_zero) begin
						cmd.pick_ev = 1'b1;
						state_nxt   = tsa_pkg::ST_PSTART;
					end else begin
						cmd.scan_adv = 1'b1;
						cmd.min_upd  = sts.ev_valid;
						if (sts.iss_done && !sts.ev_valid) begin
							state_nxt = tsa_pkg::ST_PSTOP;
						end
					end
				end else if (need_emit && sts.hold_valid && !sts.out_free) begin
					cmd.scan_rep = 1'b1;
				end else begin
					cmd.scan_adv = 1'b1;
					cmd.wr_dec   = sts.ev_valid && !sts.ev_zero;
					cmd.hold_ld  = need_emit;
					cmd.out_hold = need_emit && sts.hold_valid;
					if (sts.iss_done && !sts.ev_valid) begin
						state_nxt = tsa_pkg::ST_TFLUSH;
					end
				end
			end
			tsa_pkg::ST_TFLUSH: begin
				// parked stop item is the last one of the tick
				if (!sts.hold_valid) begin
					state_nxt = tsa_pkg::ST_IDLE;
				end else if (sts.out_free) begin
					cmd.out_hold = 1'b1;
					cmd.out_last = 1'b1;
					cmd.hold_clr = 1'b1;
					state_nxt    = tsa_pkg::ST_IDLE;
				end
			end
			tsa_pkg::ST_PSTOP: begin
				if (sts.out_free) begin
					cmd.out_stop  = 1'b1;
					cmd.pick_best = 1'b1;
					state_nxt     = tsa_pkg::ST_PSTART;
				end
			end
			tsa_pkg::ST_PSTART: begin
				if (sts.out_free) begin
					cmd.out_start = 1'b1;
					cmd.wr_dur    = 1'b1;
					state_nxt     = tsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tsa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/tsa_dpath.sv
// Datapath of the timed slot allocator: countdown memory, scan pipeline,
// minimum search, stop-item hold register and output register. Uses tsa_pkg.
module tsa_dpath #(
	parameter int NUM_SLOTS = tsa_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsa_pkg::tsa_cmd_t                cmd,
	output tsa_pkg::tsa_sts_t                sts,
	input  logic                             in_play,
	input  logic [tsa_pkg::COUNT_W-1:0]      in_duration,
	input  logic [tsa_pkg::SID_W-1:0]        in_sound_id,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int AW = IW + 1;
	localparam int CW = tsa_pkg::COUNT_W;

	// countdown memory, valid bits stand in for the reset clear
	logic [CW-1:0]        mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;

	logic [AW-1:0] iss_q;
	logic          ev_s1;
	logic [IW-1:0] ev_idx_s1;
	logic [CW-1:0] rd_s1;
	logic          rd_vld_s1;

	logic          play_q;
	logic [CW-1:0] dur_q;
	logic [tsa_pkg::SID_W-1:0] sid_q;

	logic [IW-1:0] best_q;
	logic [CW-1:0] best_val_q;
	logic [IW-1:0] chosen_q;
	logic          hold_q;
	logic [IW-1:0] hold_idx_q;
	logic [tsa_pkg::EVCNT_W-1:0] cnt_q;

	logic                      out_valid_q;
	logic                      out_kind_q;
	logic [tsa_pkg::SLOT_W-1:0] out_slot_q;
	logic [tsa_pkg::SID_W-1:0] out_sid_q;
	logic                      out_last_q;

	logic [CW-1:0] ev_val;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [CW-1:0] wr_data;
	logic          wr_en;
	logic          iss_done;
	logic          out_free;
	logic          push;
	logic [IW+3:0] hold_ext, best_ext, chosen_ext;

	assign ev_val   = rd_vld_s1 ? rd_s1 : '0;
	assign iss_done = (iss_q == AW'(NUM_SLOTS));
	assign out_free = !out_valid_q || m_axis_tready;
	assign push     = cmd.out_hold || cmd.out_stop || cmd.out_start;

	// memory port muxing
	assign rd_addr = cmd.scan_rep ? ev_idx_s1 : iss_q[IW-1:0];
	assign wr_en   = cmd.wr_dec || cmd.wr_dur;
	assign wr_addr = cmd.wr_dur ? chosen_q : ev_idx_s1;
	assign wr_data = cmd.wr_dur ? dur_q : (ev_val - CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// scan pipeline: issue index and evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			ev_s1 <= 1'b0;
		end else if (cmd.start) begin
			iss_q <= '0;
			ev_s1 <= 1'b0;
		end else if (cmd.scan_adv) begin
			if (!iss_done) begin
				ev_s1 <= 1'b1;
				iss_q <= iss_q + AW'(1);
			end else begin
				ev_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_adv && !iss_done) begin
			ev_idx_s1 <= iss_q[IW-1:0];
		end
	end

	// item fields, minimum search, chosen slot
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dur_q      <= in_duration;
			sid_q      <= in_sound_id;
			best_q     <= '0;
			best_val_q <= tsa_pkg::COUNT_MAX;
		end else if (cmd.min_upd && ev_val < best_val_q) begin
			best_q     <= ev_idx_s1;
			best_val_q <= ev_val;
		end
		if (cmd.pick_ev) begin
			chosen_q <= ev_idx_s1;
		end else if (cmd.pick_best) begin
			chosen_q <= best_q;
		end
		if (cmd.hold_ld) begin
			hold_idx_q <= ev_idx_s1;
		end
	end

	// control part of the item and the parked stop item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= 1'b0;
			hold_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			play_q <= in_play;
			hold_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.hold_ld) begin
			hold_q <= 1'b1;
			cnt_q  <= cnt_q + tsa_pkg::EVCNT_W'(1);
		end else if (cmd.hold_clr) begin
			hold_q <= 1'b0;
		end
	end

	// slot numbers carried as their low four bits
	assign hold_ext   = {{4{1'b0}}, hold_idx_q};
	assign best_ext   = {{4{1'b0}}, best_q};
	assign chosen_ext = {{4{1'b0}}, chosen_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_hold) begin
			out_kind_q <= tsa_pkg::EV_STOP;
			out_slot_q <= hold_ext[3:0];
			out_sid_q  <= '0;
			out_last_q <= cmd.out_last;
		end else if (cmd.out_stop) begin
			out_kind_q <= tsa_pkg::EV_STOP;
			out_slot_q <= best_ext[3:0];
			out_sid_q  <= '0;
			out_last_q <= 1'b0;
		end else if (cmd.out_start) begin
			out_kind_q <= tsa_pkg::EV_START;
			out_slot_q <= chosen_ext[3:0];
			out_sid_q  <= sid_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_sid_q, out_slot_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// status back to the sequencer
	assign sts.play       = play_q;
	assign sts.ev_valid   = ev_s1;
	assign sts.ev_zero    = (ev_val == '0);
	assign sts.ev_one     = (ev_val == CW'(1));
	assign sts.iss_done   = iss_done;
	assign sts.hold_valid = hold_q;
	assign sts.out_free   = out_free;
	assign sts.cap_full   = (cnt_q == tsa_pkg::EVCNT_W'(tsa_pkg::MAX_EVENTS));

	// checks
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("item pushed into a full output register");

	a_push_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.out_hold, cmd.out_stop, cmd.out_start}))
		else $error("two items pushed in one cycle");

	a_wr_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_dec && cmd.wr_dur))
		else $error("two countdown writes in one cycle");

	a_hold_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold_ld |-> (ev_s1 && ev_val == CW'(1) && !play_q))
		else $error("stop item parked for a slot not expiring");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tsa_pkg::EVCNT_W'(tsa_pkg::MAX_EVENTS))
		else $error("stop item count beyond limit");

endmodule
